### rtl/assert_macros.svh
// Assertion macros for the RTL of the group expander.
// Self-contained; included by the top module, which carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rbgexp_pkg.sv
// Package for the group-to-block expander: field widths, register indexes,
// beat widths and the group size clamp. No dependencies.
package rbgexp_pkg;

  localparam int MAP_BITS   = 64;
  localparam int MAP_IDX_W  = $clog2(MAP_BITS);
  localparam int BLOCK_W    = 9;
  localparam int GSIZE_W    = 5;
  localparam int GROUP_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int ACC_W      = GROUP_W + 4;   // group index times at most 16
  localparam int SHIFT_W    = 3;             // bit position 0..4 of the group size
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BLOCK_W;
  localparam int OUT_BITS   = BLOCK_W + COUNT_W + MAP_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [GSIZE_W-1:0] MAX_GROUP = GSIZE_W'(16);
  localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(GSIZE_W - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE     = 1'b1;

  // Group sizes above sixteen behave as sixteen.
  function automatic logic [GSIZE_W-1:0] clamp_group(input logic [GSIZE_W-1:0] size);
    return (size > MAX_GROUP) ? MAX_GROUP : size;
  endfunction

endpackage

### rtl/rbg_to_prb_expander_top.sv
// Expands resource block group indices into physical resource block beats.
// The group is accepted in IDLE, passes MUL and CHECK, and its first block beat is
// loaded in EMIT. A new group is accepted only in IDLE, after the previous run has ended;
// MUL is a 5-step shift-add multiply and CHECK one range check, both on one shared adder.
// Reset (rst, synchronous, active high): carrier 275 blocks, group size 16,
// count and map cleared, output empty, ready for a group.
`include "assert_macros.svh"

module rbg_to_prb_expander_top
  import rbgexp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes: index 0 carrier_blocks, index 1 group_size.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Group input.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [GROUP_W-1:0]    s_axis_tdata,   // [15:0] group_index
  input  logic                  s_axis_tuser,   // [0] first_of_list
  // Block output.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] block_index, [24:9] block_count,
                                                // [88:25] block_map, [95:89] zero
  output logic                  m_axis_tlast    // last_of_run
);

  // The sequencer owns one adder. In MUL it accumulates the group index
  // shifted by each set bit of the group size (start block), in CHECK it
  // forms start plus group size (end of run), and in EMIT it steps the
  // current block by one.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t               state;
  logic [BLOCK_W-1:0]   carrier;
  logic [GSIZE_W-1:0]   group_size;
  logic [GROUP_W-1:0]   group;
  logic [ACC_W-1:0]     acc;
  logic [SHIFT_W-1:0]   shift;
  logic [BLOCK_W-1:0]   blk;
  logic [BLOCK_W-1:0]   end_blk;
  logic [COUNT_W-1:0]   count;
  logic [MAP_BITS-1:0]  amap;

  logic [BLOCK_W-1:0]   out_index;
  logic [COUNT_W-1:0]   out_count;
  logic [MAP_BITS-1:0]  out_map;
  logic                 out_last;
  logic                 out_valid;

  logic [GSIZE_W-1:0]   psize;
  logic [ACC_W-1:0]     add_a;
  logic [ACC_W-1:0]     add_b;
  logic [ACC_W-1:0]     sum;
  logic [ACC_W-1:0]     carrier_ext;
  logic                 load;
  logic                 run_last;
  logic [COUNT_W-1:0]   count_next;
  logic [MAP_BITS-1:0]  amap_next;

  assign psize       = clamp_group(group_size);
  assign carrier_ext = ACC_W'(carrier);

  // Operand selection for the shared adder.
  always_comb begin
    add_a = acc;
    add_b = '0;
    unique case (state)
      ST_MUL: begin
        add_a = acc;
        add_b = psize[shift] ? (ACC_W'(group) << shift) : '0;
      end
      ST_CHECK: begin
        add_a = acc;
        add_b = ACC_W'(psize);
      end
      ST_EMIT: begin
        add_a = ACC_W'(blk);
        add_b = ACC_W'(1);
      end
      default: begin
        add_a = acc;
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b;

  // In EMIT, a new block beat is loaded whenever the output register is free or drains now.
  assign load     = (state == ST_EMIT) && (!out_valid || m_axis_tready);
  assign run_last = (sum == ACC_W'(end_blk));

  always_comb begin
    count_next = (count != COUNT_MAX) ? count + COUNT_W'(1) : count;
    amap_next  = amap;
    if (blk < BLOCK_W'(MAP_BITS)) begin
      amap_next[blk[MAP_IDX_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      carrier    <= BLOCK_W'(275);
      group_size <= MAX_GROUP;
      count      <= '0;
      amap       <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The user must write configuration only while no group is in flight; the block does not enforce this.
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CARRIER_BLOCKS: carrier    <= cfg_data;
          REG_GROUP_SIZE:     group_size <= cfg_data[GSIZE_W-1:0];
          default:            ;
        endcase
      end

      if (out_valid && m_axis_tready && !load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            group <= s_axis_tdata;
            acc   <= '0;
            shift <= '0;
            if (s_axis_tuser) begin
              count <= '0;
              amap  <= '0;
            end
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc   <= sum;
          shift <= shift + SHIFT_W'(1);
          if (shift == LAST_SHIFT) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Empty group sizes and groups past the carrier edge emit nothing.
          if (psize == '0 || acc >= carrier_ext) begin
            state <= ST_IDLE;
          end else begin
            blk     <= acc[BLOCK_W-1:0];
            end_blk <= (sum > carrier_ext) ? carrier : sum[BLOCK_W-1:0];
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_index <= blk;
            out_last  <= run_last;
            out_count <= count_next;
            out_map   <= amap_next;
            out_valid <= 1'b1;
            count     <= count_next;
            amap      <= amap_next;
            blk       <= sum[BLOCK_W-1:0];
            if (run_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_map, out_count, out_index};

  // The block being stepped never reaches the clipped end of its run.
  `ASSERT_NOW(a_blk_below_end, clk, rst, state == ST_EMIT, blk < end_blk, "block past end of run")
  // The multiply walks only the bits of the group size.
  `ASSERT_NOW(a_shift_range, clk, rst, state == ST_MUL, shift <= LAST_SHIFT, "shift out of range")
  // Every emitted beat has been counted.
  `ASSERT_NOW(a_count_nonzero, clk, rst, out_valid, out_count != '0, "beat with zero count")
  // A block inside the map is marked in its own beat.
  `ASSERT_NOW(a_map_marked, clk, rst, out_valid && (out_index < BLOCK_W'(MAP_BITS)), out_map[out_index[MAP_IDX_W-1:0]], "block not marked in map")
  // After the final block of a run the sequencer is free for the next group.
  `ASSERT_NEXT(a_idle_after_last, clk, rst, load && run_last, state == ST_IDLE, "not idle after run")

endmodule
